// File: rtl/spp_pkg.sv
// Shared types and constants for the servo instruction packet parser.
package spp_pkg;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;
  localparam logic [7:0] RESET_MAX_LEN = 8'd124;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_CSUM    = 2'd2;

  typedef struct packed {
    logic [7:0] param_count;
    logic [7:0] instruction;
    logic [7:0] servo_id;
    logic [7:0] param_byte;
    logic [7:0] param_index;
  } res_data_t;

  typedef struct packed {
    logic       param_valid;
    logic       packet_done;
    logic [1:0] status;
  } res_flags_t;

  typedef struct packed {
    res_flags_t flags;
    res_data_t  data;
  } res_t;

endpackage

// File: rtl/spp_parse.sv
// Packet parse state machine: held packet fields and per-byte result logic.
module spp_parse (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   max_length,
  output spp_pkg::res_t res
);
  import spp_pkg::*;

  localparam logic [2:0] ST_HDR1  = 3'd0;
  localparam logic [2:0] ST_HDR2  = 3'd1;
  localparam logic [2:0] ST_ID    = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_INST  = 3'd4;
  localparam logic [2:0] ST_PARAM = 3'd5;
  localparam logic [2:0] ST_CSUM  = 3'd6;

  logic [2:0] state, state_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] held_instruction, held_instruction_next;
  logic [7:0] param_position, param_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] cur_count;
  logic [7:0] next_count;
  logic [7:0] pos_inc;

  always_comb begin
    cur_count  = (held_length >= MIN_LENGTH) ? held_length - MIN_LENGTH : 8'd0;
    pos_inc    = param_position + 8'd1;

    state_next            = state;
    held_id_next          = held_id;
    held_length_next      = held_length;
    held_instruction_next = held_instruction;
    param_position_next   = param_position;
    running_sum_next      = running_sum;

    res.flags.status      = STATUS_OK;
    res.flags.packet_done = 1'b0;
    res.flags.param_valid = 1'b0;
    res.data.param_index  = 8'd0;
    res.data.param_byte   = 8'd0;

    unique case (state)
      ST_HDR2: begin
        if (rx_byte == HDR_BYTE) begin
          state_next = ST_ID;
        end else begin
          state_next       = ST_HDR1;
          res.flags.status = STATUS_INVALID;
        end
      end
      ST_ID: begin
        held_id_next     = rx_byte;
        running_sum_next = rx_byte;
        state_next       = ST_LEN;
      end
      ST_LEN: begin
        if (rx_byte < MIN_LENGTH || rx_byte > max_length) begin
          state_next       = ST_HDR1;
          res.flags.status = STATUS_INVALID;
        end else begin
          held_length_next = rx_byte;
          running_sum_next = running_sum + rx_byte;
          state_next       = ST_INST;
        end
      end
      ST_INST: begin
        held_instruction_next = rx_byte;
        running_sum_next      = running_sum + rx_byte;
        param_position_next   = 8'd0;
        state_next            = (cur_count != 8'd0) ? ST_PARAM : ST_CSUM;
      end
      ST_PARAM: begin
        res.flags.param_valid = 1'b1;
        res.data.param_index  = param_position;
        res.data.param_byte   = rx_byte;
        running_sum_next      = running_sum + rx_byte;
        param_position_next   = pos_inc;
        if (pos_inc >= cur_count) begin
          state_next = ST_CSUM;
        end
      end
      ST_CSUM: begin
        res.flags.packet_done = 1'b1;
        if (~running_sum != rx_byte) begin
          res.flags.status = STATUS_CSUM;
        end
        state_next = ST_HDR1;
      end
      default: begin
        state_next = (rx_byte == HDR_BYTE) ? ST_HDR2 : ST_HDR1;
      end
    endcase

    next_count = (held_length_next >= MIN_LENGTH) ? held_length_next - MIN_LENGTH : 8'd0;
    res.data.servo_id    = held_id_next;
    res.data.instruction = held_instruction_next;
    res.data.param_count = next_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_HDR1;
      held_id          <= 8'd0;
      held_length      <= 8'd0;
      held_instruction <= 8'd0;
      param_position   <= 8'd0;
      running_sum      <= 8'd0;
    end else if (en) begin
      state            <= state_next;
      held_id          <= held_id_next;
      held_length      <= held_length_next;
      held_instruction <= held_instruction_next;
      param_position   <= param_position_next;
      running_sum      <= running_sum_next;
    end
  end

endmodule

// File: rtl/servo_instruction_packet_parser_top.sv
// Path: an input byte is captured in the input register, parsed, then held in the result register for the master side.
// Throughput: one byte per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst, synchronous): parser hunts for the first header, held id,
// length, instruction, position and sum clear, max_length returns to 124.
module servo_instruction_packet_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] param_index, [15:8] param_byte,
                                      // [23:16] servo_id, [31:24] instruction,
                                      // [39:32] param_count
  output logic [3:0]  m_axis_tuser,   // [1:0] status, [2] packet_done, [3] param_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // max_length
);
  import spp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  res_t       out_res;
  res_t       res;
  logic [7:0] max_length;
  logic       advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  spp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .en         (in_valid && advance),
    .rx_byte    (in_byte),
    .max_length (max_length),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= RESET_MAX_LEN;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = out_res.flags;

endmodule

// File: rtl/spp_checker.sv
// Port-level checker for the packet parser top level, with its bind.
module spp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import spp_pkg::*;

  a_done_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] != STATUS_INVALID)
    else $error("packet_done with invalid packet status");

  a_param_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |->
      !m_axis_tuser[2] && m_axis_tuser[1:0] == STATUS_OK)
    else $error("parameter transaction carries done or error");

  a_param_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tdata[7:0] < m_axis_tdata[39:32])
    else $error("parameter index beyond parameter count");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind servo_instruction_packet_parser_top spp_checker u_spp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
